### rtl/core/pci_pkg.sv
// types and constants shared by the pulse charge integrator
package pci_pkg;

  localparam int MAX_TRACE_LEN = 1024;
  localparam int BASE_LEN      = 20;
  localparam int SAMPLE_BITS   = 16;

  localparam int IDX_W    = $clog2(MAX_TRACE_LEN);
  localparam int CNT_W    = $clog2(MAX_TRACE_LEN + 1);
  localparam int BASE_MAX = BASE_LEN * ((1 << SAMPLE_BITS) - 1);
  localparam int BASE_W   = $clog2(BASE_MAX + 1);
  localparam longint unsigned ACC_MAX = 64'd2 * 64'(MAX_TRACE_LEN - 1) * 64'(BASE_LEN)
                                        * 64'((1 << SAMPLE_BITS) - 1);
  localparam int ACC_W    = $clog2(ACC_MAX + 64'd1);
  localparam int MIN_LEN  = (BASE_LEN > 11) ? BASE_LEN : 11;
  localparam int WIN_W    = ((CNT_W > 8) ? CNT_W : 8) + 2;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_PRE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_POST = CFG_IDX_W'(1);
  localparam logic [7:0] PRE_RESET  = 8'd20;
  localparam logic [7:0] POST_RESET = 8'd40;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_SHORT = 2'd1;
  localparam logic [1:0] ST_CLIP  = 2'd2;

  typedef struct packed {
    logic [15:0] sample;
    logic        last;
  } pci_in_t;

  typedef struct packed {
    logic [31:0] charge_scaled;
    logic [9:0]  peak_index;
    logic [20:0] baseline_sum;
    logic [1:0]  status;
  } pci_res_t;

endpackage

### rtl/core/pulse_charge_integrator_top.sv
// pulse charge integrator: trace store, baseline, peak search and window integration
//
//   channel  direction  handshake              payload
//   request  in         start / busy           item_i  (sample, last)
//   result   out        done_o strobe          result_o (charge, peak, baseline, status)
//   config   in         cfg_valid_i / ready_o  cfg_index_i, cfg_data_i
//
// samples are taken one per cycle while busy is low
// after a last sample the block is busy while the single trace memory read port
// walks the window one entry a cycle, then drains the pipeline before the result
// a trace that is too short, or whose window is empty, goes from setup straight to done
// results appear for one cycle on done_o and cannot be stalled
// reset returns the sequencer to idle and config registers to 20 and 40
module pulse_charge_integrator_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  pci_pkg::pci_in_t              item_i,
  output logic                          done_o,
  output pci_pkg::pci_res_t             result_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [pci_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [pci_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SETUP = 3'd1;
  localparam logic [2:0] S_RUN   = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  localparam int SB    = pci_pkg::SAMPLE_BITS;
  localparam int IW    = pci_pkg::IDX_W;
  localparam int CW    = pci_pkg::CNT_W;
  localparam int BW    = pci_pkg::BASE_W;
  localparam int AW    = pci_pkg::ACC_W;
  localparam int WW    = pci_pkg::WIN_W;
  localparam logic [BW-1:0] BASE_LEN_C = BW'(pci_pkg::BASE_LEN);

  logic [2:0]    state_q, state_d;
  logic [7:0]    pre_q, post_q;
  logic [CW-1:0] cnt_q;
  logic [BW-1:0] base_q;
  logic [SB-1:0] peak_val_q;
  logic [IW-1:0] peak_pos_q;

  logic [SB-1:0] trace_mem [pci_pkg::MAX_TRACE_LEN];
  logic [SB-1:0] rd_data_q;
  logic          rd_vld_q, f_vld_q, pair_vld_q, first_q;
  logic [BW-1:0] f_q, prev_q;
  logic [BW:0]   pair_q;
  logic [AW-1:0] acc_q;
  logic [1:0]    status_q;
  logic [IW-1:0] idx_q, end_q;

  logic          accept;
  logic [SB-1:0] smp;
  logic          room;
  logic          short_trace;
  logic signed [WW-1:0] lo_s, hi_s, n_s, lo_c, hi_c, lo_m1, hi_m1;
  logic          lo_clip, hi_clip, empty_win;
  logic [BW-1:0] prod;
  logic          pipe_empty;

  assign accept      = start && !busy;
  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign smp         = item_i.sample[SB-1:0];
  assign room        = (cnt_q < CW'(pci_pkg::MAX_TRACE_LEN));

  // window bounds from the gathered trace
  assign short_trace = (cnt_q < CW'(pci_pkg::MIN_LEN));
  assign lo_s    = $signed(WW'(peak_pos_q)) - $signed(WW'(pre_q));
  assign hi_s    = $signed(WW'(peak_pos_q)) + $signed(WW'(post_q));
  assign n_s     = $signed(WW'(cnt_q));
  assign lo_clip = (lo_s < $signed(WW'(1)));
  assign hi_clip = (hi_s > n_s);
  assign lo_c    = lo_clip ? $signed(WW'(1)) : lo_s;
  assign hi_c    = hi_clip ? n_s : hi_s;
  assign empty_win = (lo_c >= hi_c);
  assign lo_m1   = lo_c - $signed(WW'(1));
  assign hi_m1   = hi_c - $signed(WW'(1));

  assign prod       = BASE_LEN_C * BW'(rd_data_q);
  assign pipe_empty = !rd_vld_q && !f_vld_q && !pair_vld_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept && item_i.last) state_d = S_SETUP;
      end
      S_SETUP: begin
        if (short_trace || empty_win) state_d = S_DONE;
        else state_d = S_RUN;
      end
      S_RUN: begin
        if (idx_q == end_q) state_d = S_DRAIN;
      end
      S_DRAIN: begin
        if (pipe_empty) state_d = S_DONE;
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      pre_q      <= pci_pkg::PRE_RESET;
      post_q     <= pci_pkg::POST_RESET;
      cnt_q      <= '0;
      base_q     <= '0;
      peak_val_q <= '0;
      peak_pos_q <= '0;
      rd_vld_q   <= 1'b0;
      f_vld_q    <= 1'b0;
      pair_vld_q <= 1'b0;
      first_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      rd_vld_q   <= (state_q == S_RUN);
      f_vld_q    <= rd_vld_q;
      pair_vld_q <= f_vld_q && !first_q;
      if (state_q == S_SETUP) first_q <= 1'b1;
      else if (f_vld_q) first_q <= 1'b0;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == pci_pkg::CFG_PRE) pre_q <= cfg_data_i;
        else if (cfg_index_i == pci_pkg::CFG_POST) post_q <= cfg_data_i;
      end
      if (accept && room) begin
        if (cnt_q < CW'(pci_pkg::BASE_LEN)) base_q <= base_q + BW'(smp);
        if (cnt_q == '0 || smp > peak_val_q) begin
          peak_val_q <= smp;
          peak_pos_q <= cnt_q[IW-1:0];
        end
        cnt_q <= cnt_q + CW'(1);
      end
      if (state_q == S_DONE) begin
        cnt_q      <= '0;
        base_q     <= '0;
        peak_val_q <= '0;
        peak_pos_q <= '0;
      end
    end
  end

  // trace memory, written while loading and read while walking the window
  always_ff @(posedge clk_i) begin
    if (accept && room) trace_mem[cnt_q[IW-1:0]] <= smp;
    if (state_q == S_RUN) rd_data_q <= trace_mem[idx_q];
  end

  // window walk: term, pair of neighbouring terms, accumulate
  always_ff @(posedge clk_i) begin
    f_q <= (prod > base_q) ? (prod - base_q) : (base_q - prod);
    if (f_vld_q) begin
      prev_q <= f_q;
      pair_q <= (BW + 1)'(prev_q) + (BW + 1)'(f_q);
    end
    if (state_q == S_SETUP) begin
      acc_q    <= '0;
      idx_q    <= lo_m1[IW-1:0];
      end_q    <= hi_m1[IW-1:0];
      if (short_trace) status_q <= pci_pkg::ST_SHORT;
      else if (lo_clip || hi_clip) status_q <= pci_pkg::ST_CLIP;
      else status_q <= pci_pkg::ST_OK;
    end else begin
      if (pair_vld_q) acc_q <= acc_q + AW'(pair_q);
      if (state_q == S_RUN && idx_q != end_q) idx_q <= idx_q + IW'(1);
    end
  end

  assign done_o = (state_q == S_DONE);
  assign result_o.charge_scaled = (64'(acc_q) > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(acc_q);
  assign result_o.peak_index    = 10'(peak_pos_q);
  assign result_o.baseline_sum  = 21'(base_q);
  assign result_o.status        = status_q;

`ifndef SYNTHESIS
  a_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && item_i.last) |=> busy)
    else $error("last sample did not start the window pass");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy)
    else $error("block did not return to idle after a result");
  a_read_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> (state_q == S_RUN || state_q == S_DRAIN))
    else $error("memory read outside the window walk");
  a_short_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.status == pci_pkg::ST_SHORT) |-> (result_o.charge_scaled == 32'd0))
    else $error("too-short trace gave a nonzero charge");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(pci_pkg::MAX_TRACE_LEN))
    else $error("sample count beyond trace store depth");
`endif

endmodule

### sim/pulse_charge_integrator_checker.sv
// checker for the pulse charge integrator: predicts each trace result and compares it
`timescale 1ns / 100ps
module pulse_charge_integrator_checker
  import pci_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic                   busy_i,
  input  pci_in_t                item_i,
  input  logic                   done_i,
  input  pci_res_t               result_i,
  input  logic                   cfg_valid_i,
  input  logic                   cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  output int                     fail_count_o,
  output int                     pending_o,
  output int                     checked_o
);

  logic [15:0] trace_mem [MAX_TRACE_LEN];
  int          n_taken;
  int          base_sum;
  logic [15:0] peak_val;
  int          peak_pos;
  int          pre_len;
  int          post_len;
  pci_res_t    predicted_results [$];
  pci_res_t    predicted;
  pci_res_t    want;

  function automatic bit integrate_sample(input pci_in_t req, output pci_res_t res);
    longint unsigned acc;
    longint          a;
    longint          b;
    longint          base;
    int              n;
    int              lo;
    int              hi;
    logic [1:0]      st;
    res = '0;
    if (n_taken < MAX_TRACE_LEN) begin
      trace_mem[n_taken] = req.sample;
      if (n_taken < BASE_LEN) base_sum += req.sample;
      if (n_taken == 0 || req.sample > peak_val) begin
        peak_val = req.sample;
        peak_pos = n_taken;
      end
      n_taken++;
    end
    if (!req.last) return 1'b0;
    n = n_taken;
    st = ST_OK;
    acc = 0;
    base = longint'(base_sum);
    if (n < MIN_LEN) begin
      st = ST_SHORT;
    end else begin
      lo = peak_pos - pre_len;
      hi = peak_pos + post_len;
      if (lo < 1) begin
        lo = 1;
        st = ST_CLIP;
      end
      if (hi > n) begin
        hi = n;
        st = ST_CLIP;
      end
      for (int i = lo; i < hi; i++) begin
        a = longint'(BASE_LEN) * longint'(trace_mem[i-1]);
        b = longint'(BASE_LEN) * longint'(trace_mem[i]);
        acc += (a > base) ? a - base : base - a;
        acc += (b > base) ? b - base : base - b;
      end
      if (acc > 64'hFFFF_FFFF) acc = 64'hFFFF_FFFF;
    end
    res.charge_scaled = acc[31:0];
    res.peak_index    = 10'(peak_pos);
    res.baseline_sum  = 21'(base_sum);
    res.status        = st;
    n_taken  = 0;
    base_sum = 0;
    peak_val = '0;
    peak_pos = 0;
    return 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_taken  = 0;
      base_sum = 0;
      peak_val = '0;
      peak_pos = 0;
      pre_len  = int'(PRE_RESET);
      post_len = int'(POST_RESET);
      predicted_results.delete();
      fail_count_o = 0;
      checked_o    = 0;
      pending_o    = 0;
    end else begin
      if (done_i) begin
        if (predicted_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, got charge %0d peak %0d base %0d st %0d",
                   $time, result_i.charge_scaled, result_i.peak_index,
                   result_i.baseline_sum, result_i.status);
          fail_count_o++;
        end else begin
          want = predicted_results.pop_front();
          checked_o++;
          if (result_i !== want) begin
            fail_count_o++;
            if (result_i.charge_scaled !== want.charge_scaled)
              $display("%0t: charge_scaled expected %0d got %0d", $time,
                       want.charge_scaled, result_i.charge_scaled);
            if (result_i.peak_index !== want.peak_index)
              $display("%0t: peak_index expected %0d got %0d", $time,
                       want.peak_index, result_i.peak_index);
            if (result_i.baseline_sum !== want.baseline_sum)
              $display("%0t: baseline_sum expected %0d got %0d", $time,
                       want.baseline_sum, result_i.baseline_sum);
            if (result_i.status !== want.status)
              $display("%0t: status expected %0d got %0d", $time,
                       want.status, result_i.status);
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_PRE:  pre_len  = int'(cfg_data_i);
          CFG_POST: post_len = int'(cfg_data_i);
          default: ;
        endcase
      end
      if (start_i && !busy_i) begin
        if (integrate_sample(item_i, predicted))
          predicted_results.insert(predicted_results.size(), predicted);
      end
      pending_o = predicted_results.size();
    end
  end

endmodule

### sim/pulse_charge_integrator_top_tb.sv
// testbench top for the pulse charge integrator: trace stimulus, window settings and verdict
`timescale 1ns / 100ps
module pulse_charge_integrator_top_tb;
  import pci_pkg::*;

  localparam int LIMIT_CYCLES = 800000;
  localparam int PHASE_ITEMS  = 115;

  typedef enum int {SHAPE_PULSE, SHAPE_DIP, SHAPE_NOISE, SHAPE_FLAT} shape_e;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  start     = 1'b0;
  logic                  busy;
  pci_in_t               item      = '0;
  logic                  done;
  pci_res_t              result;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_PRE;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  int fails;
  int pending;
  int checked;
  int idle_pct  = 36;
  int n_items   = 0;
  int n_traces  = 0;
  int n_writes  = 0;
  int cycles    = 0;

  always #5 clk = ~clk;

  pulse_charge_integrator_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .start       (start),
    .busy        (busy),
    .item_i      (item),
    .done_o      (done),
    .result_o    (result),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  pulse_charge_integrator_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .start_i      (start),
    .busy_i       (busy),
    .item_i       (item),
    .done_i       (done),
    .result_i     (result),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fails),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  // one sample request, held until taken
  task automatic push_sample(input logic [15:0] value, input logic lst);
    while ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    start       = 1'b1;
    item.sample = value;
    item.last   = lst;
    do @(posedge clk); while (busy);
    @(negedge clk);
    n_items++;
  endtask

  task automatic play_trace(input int len, input shape_e shape);
    int base;
    int amp;
    int pk;
    int d;
    int v;
    int noise;
    base = ($urandom_range(3) == 0) ? int'($urandom_range(65535))
                                    : int'($urandom_range(4000, 100));
    amp  = int'($urandom_range(65535, 1));
    case ($urandom_range(3))
      0:       pk = 0;
      1:       pk = len - 1;
      default: pk = int'($urandom_range(len - 1));
    endcase
    for (int i = 0; i < len; i++) begin
      d     = (i > pk) ? i - pk : pk - i;
      noise = int'($urandom_range(15));
      case (shape)
        SHAPE_PULSE: begin
          v = base + noise + ((d > 16) ? 0 : (amp >> d));
          if (v > 65535) v = 65535;
        end
        SHAPE_DIP: begin
          v = base - noise - ((d > 16) ? 0 : (amp >> d));
          if (v < 0) v = 0;
        end
        SHAPE_NOISE: v = int'($urandom_range(65535));
        default:     v = base;
      endcase
      push_sample(v[15:0], i == len - 1);
    end
    n_traces++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
    n_writes++;
  endtask

  // drain outstanding results and let the window pass finish
  task automatic settle();
    start = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (32) @(negedge clk);
    while (busy) @(negedge clk);
  endtask

  initial begin
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int r;
    int phase_base;
    logic [7:0] pre_v;
    logic [7:0] post_v;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // single sample trace, then a spike in the middle of a minimum length trace
    push_sample(16'hFFFF, 1'b1);
    for (int i = 0; i < 20; i++) push_sample((i == 10) ? 16'hFFFF : 16'h0000, i == 19);
    n_traces += 2;

    for (int p = 0; p < 6; p++) begin
      settle();
      case (p)
        0:       begin pre_v = 8'd1;   post_v = 8'd1;   end
        1:       begin pre_v = 8'd255; post_v = 8'd255; end
        2:       begin pre_v = 8'd1;   post_v = 8'd255; end
        3:       begin pre_v = 8'd255; post_v = 8'd1;   end
        4:       begin pre_v = 8'($urandom_range(255, 1)); post_v = 8'($urandom_range(255, 1)); end
        default: begin pre_v = 8'($urandom_range(40, 1));  post_v = 8'($urandom_range(60, 1));  end
      endcase
      write_reg(CFG_PRE, pre_v);
      write_reg(CFG_POST, post_v);
      idle_pct   = (p < 2) ? 36 : (p < 4) ? 62 : 0;
      phase_base = n_items;
      while (n_items - phase_base < PHASE_ITEMS) begin
        r = int'($urandom_range(99));
        if (r < 5)       play_trace(int'($urandom_range(300, 100)), SHAPE_PULSE);
        else if (r < 60) play_trace(int'($urandom_range(48, 20)), SHAPE_PULSE);
        else if (r < 72) play_trace(int'($urandom_range(48, 20)), SHAPE_DIP);
        else if (r < 84) play_trace(int'($urandom_range(19, 1)),
                                    (r < 78) ? SHAPE_NOISE : SHAPE_PULSE);
        else if (r < 94) play_trace(int'($urandom_range(60, 20)), SHAPE_NOISE);
        else             play_trace(int'($urandom_range(40, 20)), SHAPE_FLAT);
      end
    end

    settle();
    $display("run covered %0d traces of %0d samples with %0d register writes over six windows",
             n_traces, n_items, n_writes);
    $display("%0d results compared, %0d with mismatches", checked, fails);
    if (fails == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
